// File: rtl/tcce_pkg.sv
// tcce_pkg: command codes, character codes, cell constants and the
// controller/datapath interface structs of the text console char engine.
// No dependencies.
package tcce_pkg;

    // item command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    localparam int TAB_STEP = 4;

    // blank in white on black, the screen contents after reset
    localparam logic [15:0] RESET_CELL = 16'h0F20;

    // configuration register indexes
    localparam logic CFG_FG_COLOR = 1'b0;
    localparam logic CFG_BG_COLOR = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // latch the input item
        logic exec;      // run the latched command
        logic scr_rd;    // scroll: read cell one row below the sweep
        logic scr_wr;    // scroll: write that cell at the sweep, advance
        logic fill_wr;   // write fill value at the sweep, advance
        logic load_out;  // load the result registers
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic       scroll_needed;
        logic       copy_last;
        logic       fill_last;
    } dp_status_t;

endpackage

// File: rtl/tcce_ctrl.sv
// tcce_ctrl: sequencing state machine of the text console char engine.
// Uses tcce_pkg.
module tcce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  tcce_pkg::dp_status_t  status,
    output tcce_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept     = s_valid && s_ready;
        unique case (state_reg)
            ST_INIT: begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                unique case (status.command)
                    tcce_pkg::CMD_PUT:   state_next = status.scroll_needed ? ST_SCR_RD : ST_DONE;
                    tcce_pkg::CMD_CLEAR: state_next = ST_FILL;
                    tcce_pkg::CMD_SET:   state_next = ST_DONE;
                    tcce_pkg::CMD_READ:  state_next = ST_DONE;
                    default:             state_next = ST_DONE;
                endcase
            end
            ST_SCR_RD: begin
                cmd.scr_rd = 1'b1;
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                cmd.scr_wr = 1'b1;
                state_next = status.copy_last ? ST_FILL : ST_SCR_RD;
            end
            ST_FILL: begin
                cmd.fill_wr = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/tcce_datapath.sv
// tcce_datapath: screen store, cursor, color registers, sweep counter and
// result registers of the text console char engine. Uses tcce_pkg.
module tcce_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tcce_pkg::ctrl_cmd_t   cmd,
    output tcce_pkg::dp_status_t  status,
    input  logic [1:0]            s_command,
    input  logic [7:0]            s_char_code,
    input  logic [7:0]            s_col,
    input  logic [7:0]            s_row,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [3:0]            cfg_data,
    output logic [6:0]            m_cursor_col,
    output logic [4:0]            m_cursor_row,
    output logic [10:0]           m_cursor_offset,
    output logic [15:0]           m_cell_value
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] FILL_LAST = AW'(CELLS - 1);

    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;

    logic [1:0]    command_reg;
    logic [7:0]    char_reg;
    logic [7:0]    col_in_reg;
    logic [7:0]    row_in_reg;

    logic [3:0]    fg_reg;
    logic [3:0]    bg_reg;
    logic [6:0]    col_reg;
    logic [4:0]    line_reg;
    logic [AW-1:0] sweep_reg;
    logic [15:0]   fill_val_reg;

    logic [6:0]    out_col_reg;
    logic [4:0]    out_row_reg;
    logic [10:0]   out_off_reg;
    logic [15:0]   out_cell_reg;

    logic          in_range;
    logic [15:0]   blank;
    logic [7:0]    cc;
    logic [7:0]    col_calc;
    logic          line_inc;
    logic [7:0]    put_wcol;
    logic          put_wr;
    logic [15:0]   put_data;
    logic [5:0]    line_sum;
    logic          scroll;
    logic [6:0]    put_col_next;
    logic [4:0]    put_line_next;
    logic [AW-1:0] put_addr;
    logic [AW-1:0] read_addr;
    logic [31:0]   offset_full;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign in_range = (col_in_reg < 8'(COLUMNS)) && (row_in_reg < 8'(ROWS));
    assign blank    = {bg_reg, fg_reg, tcce_pkg::BLANK_CHAR};
    assign cc       = {1'b0, col_reg};

    // put character: cursor motion and the cell it writes
    always_comb begin
        col_calc = cc;
        line_inc = 1'b0;
        put_wr   = 1'b0;
        put_wcol = cc;
        put_data = {bg_reg, fg_reg, char_reg};
        unique case (char_reg)
            tcce_pkg::CH_NEWLINE: begin
                col_calc = 8'd0;
                line_inc = 1'b1;
            end
            tcce_pkg::CH_RETURN: begin
                col_calc = 8'd0;
            end
            tcce_pkg::CH_TAB: begin
                col_calc = (cc + 8'(tcce_pkg::TAB_STEP)) & ~8'(tcce_pkg::TAB_STEP - 1);
            end
            tcce_pkg::CH_BACKSPACE: begin
                if (cc != 8'd0) begin
                    col_calc = cc - 8'd1;
                    put_wcol = cc - 8'd1;
                    put_wr   = 1'b1;
                    put_data = blank;
                end
            end
            default: begin
                col_calc = cc + 8'd1;
                put_wr   = 1'b1;
            end
        endcase
        if (col_calc >= 8'(COLUMNS)) begin
            col_calc = 8'd0;
            line_inc = 1'b1;
        end
        line_sum      = {1'b0, line_reg} + {5'd0, line_inc};
        scroll        = line_sum >= 6'(ROWS);
        put_col_next  = col_calc[6:0];
        put_line_next = scroll ? 5'(ROWS - 1) : line_sum[4:0];
    end

    assign put_addr    = AW'(32'(line_reg) * COLUMNS + 32'(put_wcol));
    assign read_addr   = AW'(32'(row_in_reg) * COLUMNS + 32'(col_in_reg));
    assign offset_full = 32'(line_reg) * COLUMNS + 32'(col_reg);

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = fill_val_reg;
        priority if (cmd.exec && (command_reg == tcce_pkg::CMD_PUT) && put_wr) begin
            wr_en   = 1'b1;
            wr_addr = put_addr;
            wr_data = put_data;
        end else if (cmd.scr_wr) begin
            wr_en   = 1'b1;
            wr_data = rdata_reg;
        end else if (cmd.fill_wr) begin
            wr_en   = 1'b1;
        end else begin
            wr_en   = 1'b0;
        end
        rd_en   = cmd.scr_rd || (cmd.exec && (command_reg == tcce_pkg::CMD_READ) && in_range);
        rd_addr = cmd.scr_rd ? AW'(32'(sweep_reg) + COLUMNS) : read_addr;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // latched item
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            command_reg <= s_command;
            char_reg    <= s_char_code;
            col_in_reg  <= s_col;
            row_in_reg  <= s_row;
        end
    end

    // colors, cursor, sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg       <= 4'd15;
            bg_reg       <= 4'd0;
            col_reg      <= '0;
            line_reg     <= '0;
            sweep_reg    <= '0;
            fill_val_reg <= tcce_pkg::RESET_CELL;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tcce_pkg::CFG_FG_COLOR: fg_reg <= cfg_data;
                    tcce_pkg::CFG_BG_COLOR: bg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                sweep_reg    <= '0;
                fill_val_reg <= blank;
                unique case (command_reg)
                    tcce_pkg::CMD_PUT: begin
                        col_reg  <= put_col_next;
                        line_reg <= put_line_next;
                    end
                    tcce_pkg::CMD_CLEAR: begin
                        col_reg  <= '0;
                        line_reg <= '0;
                    end
                    tcce_pkg::CMD_SET: begin
                        if (in_range) begin
                            col_reg  <= col_in_reg[6:0];
                            line_reg <= row_in_reg[4:0];
                        end
                    end
                    default: ;
                endcase
            end else if (cmd.scr_wr || cmd.fill_wr) begin
                sweep_reg <= sweep_reg + AW'(1);
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_col_reg  <= col_reg;
            out_row_reg  <= line_reg;
            out_off_reg  <= offset_full[10:0];
            out_cell_reg <= ((command_reg == tcce_pkg::CMD_READ) && in_range) ? rdata_reg : 16'd0;
        end
    end

    assign m_cursor_col    = out_col_reg;
    assign m_cursor_row    = out_row_reg;
    assign m_cursor_offset = out_off_reg;
    assign m_cell_value    = out_cell_reg;

    assign status.command       = command_reg;
    assign status.scroll_needed = scroll;
    assign status.copy_last     = sweep_reg == COPY_LAST;
    assign status.fill_last     = sweep_reg == FILL_LAST;

endmodule

// File: rtl/text_console_char_engine.sv
// Text console char engine: COLUMNS x ROWS screen of 16-bit cells.
// Put, set cursor and read cell items run one execute state, then a result
// load state; the next item can be accepted there once the output is free.
// Clear adds a fill sweep over every cell; a scroll adds a sweep that reads
// and writes each moved cell one row up, then a fill of the bottom row.
// Reset: sync, active low; then a blanking pass over all cells, s_ready low.
module text_console_char_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_col,
    input  logic [7:0]  s_row,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_cursor_col,
    output logic [4:0]  m_cursor_row,
    output logic [10:0] m_cursor_offset,
    output logic [15:0] m_cell_value,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    tcce_pkg::ctrl_cmd_t  ctrl_cmd;
    tcce_pkg::dp_status_t dp_status;

    // Controller: owns handshake state and the sweep sequencing.
    tcce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // Datapath: screen store, cursor math, colors, result registers.
    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctrl_cmd),
        .status          (dp_status),
        .s_command       (s_command),
        .s_char_code     (s_char_code),
        .s_col           (s_col),
        .s_row           (s_row),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_offset (m_cursor_offset),
        .m_cell_value    (m_cell_value)
    );

    // reported cursor always on screen
    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((32'(m_cursor_col) < COLUMNS) && (32'(m_cursor_row) < ROWS)))
        else $error("cursor off screen");

    // offset agrees with reported row and column
    a_offset_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_offset ==
            11'(32'(m_cursor_row) * COLUMNS + 32'(m_cursor_col))))
        else $error("cursor offset mismatch");

    // no item taken while the store is being swept
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.fill_wr || ctrl_cmd.scr_wr || ctrl_cmd.scr_rd) |-> !s_ready)
        else $error("input accepted during sweep");

endmodule
